[hdl/phq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phq_pkg
// Shared types and constants of the piezo hit qualifier: beat formats,
// configuration register map and reset values.
// ----------------------------------------------------------------------------
package phq_pkg;

    localparam int PHQ_DRUMS       = 2;
    localparam int PHQ_DRUM_W      = 1;
    localparam int PHQ_SAMPLE_W    = 12;
    localparam int PHQ_TIME_W      = 32;
    localparam int PHQ_THR_W       = 11;
    localparam int PHQ_COOL_W      = 16;
    localparam int PHQ_RUN_W       = 4;
    localparam int PHQ_SPA_DEFAULT = 3;
    localparam int PHQ_SPA_MAX     = 8;
    localparam int PHQ_SUM_MAX_W   = PHQ_SAMPLE_W + $clog2(PHQ_SPA_MAX);
    localparam int PHQ_QUEUE_DEPTH = 4;

    localparam logic [PHQ_RUN_W-1:0] PHQ_RUN_MAX = 4'd15;

    localparam int PHQ_CFG_IDX_W  = 2;
    localparam int PHQ_CFG_DATA_W = 16;

    localparam logic [PHQ_CFG_IDX_W-1:0] PHQ_REG_THR0     = 2'd0;
    localparam logic [PHQ_CFG_IDX_W-1:0] PHQ_REG_THR1     = 2'd1;
    localparam logic [PHQ_CFG_IDX_W-1:0] PHQ_REG_COOLDOWN = 2'd2;
    localparam logic [PHQ_CFG_IDX_W-1:0] PHQ_REG_MIN_CONS = 2'd3;

    localparam logic [PHQ_THR_W-1:0]  PHQ_THR0_RESET     = 11'd50;
    localparam logic [PHQ_THR_W-1:0]  PHQ_THR1_RESET     = 11'd0;
    localparam logic [PHQ_COOL_W-1:0] PHQ_COOLDOWN_RESET = 16'd100;
    localparam logic [PHQ_RUN_W-1:0]  PHQ_MIN_CONS_RESET = 4'd2;

    typedef struct packed {
        logic [PHQ_DRUM_W-1:0]   drum;
        logic [PHQ_SAMPLE_W-1:0] sample;
        logic [PHQ_TIME_W-1:0]   now_ms;
    } t_in_beat;

    typedef struct packed {
        logic                    average_valid;
        logic                    hit;
        logic [PHQ_DRUM_W-1:0]   hit_drum;
        logic [PHQ_SAMPLE_W-1:0] average;
    } t_out_beat;

    typedef struct packed {
        logic [PHQ_THR_W-1:0]  threshold_drum0;
        logic [PHQ_THR_W-1:0]  threshold_drum1;
        logic [PHQ_COOL_W-1:0] cooldown_ms;
        logic [PHQ_RUN_W-1:0]  min_consecutive;
    } t_cfg;

    typedef struct packed {
        logic [PHQ_DRUM_W-1:0]    drum;
        logic                     group_done;
        logic [PHQ_SUM_MAX_W-1:0] sum;
        logic [PHQ_TIME_W-1:0]    now_ms;
    } t_work;

endpackage

[hdl/phq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phq_front
// Accepts sample beats, keeps the per-drum group sums and counts and hands
// each sample to the queue marked with whether it closed a group.
// ----------------------------------------------------------------------------
module phq_front #(
    parameter int SAMPLES_PER_AVERAGE = phq_pkg::PHQ_SPA_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  phq_pkg::t_in_beat i_data,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output phq_pkg::t_work   o_work
);

    localparam int SUM_W = phq_pkg::PHQ_SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    logic [SUM_W-1:0] r_sum [phq_pkg::PHQ_DRUMS];
    logic [CNT_W-1:0] r_cnt [phq_pkg::PHQ_DRUMS];

    logic             accept;
    logic             done;
    logic [SUM_W-1:0] n_sum;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign done    = (r_cnt[i_data.drum] == CNT_LAST);
    assign n_sum   = r_sum[i_data.drum] + SUM_W'(i_data.sample);

    assign o_push            = accept;
    assign o_work.drum       = i_data.drum;
    assign o_work.group_done = done;
    assign o_work.sum        = phq_pkg::PHQ_SUM_MAX_W'(n_sum);
    assign o_work.now_ms     = i_data.now_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < phq_pkg::PHQ_DRUMS; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else if (accept) begin
            if (done) begin
                r_sum[i_data.drum] <= '0;
                r_cnt[i_data.drum] <= '0;
            end else begin
                r_sum[i_data.drum] <= n_sum;
                r_cnt[i_data.drum] <= CNT_W'(r_cnt[i_data.drum] + 1'b1);
            end
        end
    end

endmodule

[hdl/phq_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phq_queue
// Short first-in first-out queue of classified samples between the front
// and the back, so that either side may stall on its own.
// ----------------------------------------------------------------------------
module phq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  phq_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output phq_pkg::t_work o_head
);

    localparam int DEPTH = phq_pkg::PHQ_QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    phq_pkg::t_work   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

endmodule

[hdl/phq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phq_back
// Divides each completed group sum by a reciprocal multiply, then applies the
// threshold, consecutive-high count and cooldown per drum into the result
// register.
// ----------------------------------------------------------------------------
module phq_back #(
    parameter int SAMPLES_PER_AVERAGE = phq_pkg::PHQ_SPA_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  phq_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  phq_pkg::t_work     i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output phq_pkg::t_out_beat o_data
);

    localparam int SUM_W  = phq_pkg::PHQ_SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int SHIFT  = SUM_W + 3;
    localparam int REC_W  = SHIFT + 1;
    localparam int PROD_W = SUM_W + REC_W;
    localparam logic [REC_W-1:0] RECIP =
        REC_W'(((1 << SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    // divide stage
    logic                              r_a_valid;
    logic [phq_pkg::PHQ_DRUM_W-1:0]    r_a_drum;
    logic                              r_a_done;
    logic [PROD_W-1:0]                 r_a_prod;
    logic [phq_pkg::PHQ_TIME_W-1:0]    r_a_now;

    // per-drum qualifier state
    logic [phq_pkg::PHQ_RUN_W-1:0]  r_run  [phq_pkg::PHQ_DRUMS];
    logic [phq_pkg::PHQ_TIME_W-1:0] r_last [phq_pkg::PHQ_DRUMS];

    // result register
    logic               r_b_valid;
    phq_pkg::t_out_beat r_b_data;

    logic                            a_move;
    logic [phq_pkg::PHQ_SAMPLE_W-1:0] avg;
    logic [phq_pkg::PHQ_THR_W-1:0]    thr;
    logic                            above;
    logic [phq_pkg::PHQ_RUN_W-1:0]   run_inc;
    logic [phq_pkg::PHQ_TIME_W-1:0]  elapsed;
    logic                            cool_ok;
    logic                            b_hit;
    logic [phq_pkg::PHQ_RUN_W-1:0]   n_run;

    assign a_move = r_a_valid && (!r_b_valid || !i_stall);
    assign o_pop  = !i_empty && (!r_a_valid || a_move);

    assign avg     = r_a_prod[SHIFT +: phq_pkg::PHQ_SAMPLE_W];
    assign thr     = (r_a_drum == '0) ? i_cfg.threshold_drum0 : i_cfg.threshold_drum1;
    assign above   = r_a_done && (avg > phq_pkg::PHQ_SAMPLE_W'(thr));
    assign run_inc = (r_run[r_a_drum] == phq_pkg::PHQ_RUN_MAX) ? phq_pkg::PHQ_RUN_MAX
                   : phq_pkg::PHQ_RUN_W'(r_run[r_a_drum] + 1'b1);
    assign elapsed = r_a_now - r_last[r_a_drum];
    assign cool_ok = (elapsed >= phq_pkg::PHQ_TIME_W'(i_cfg.cooldown_ms));
    assign b_hit   = above && (run_inc >= i_cfg.min_consecutive) && cool_ok;

    always_comb begin
        n_run = r_run[r_a_drum];
        if (r_a_done) begin
            n_run = (above && !b_hit) ? run_inc : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_drum <= i_head.drum;
            r_a_done <= i_head.group_done;
            r_a_now  <= i_head.now_ms;
            r_a_prod <= i_head.group_done
                      ? PROD_W'(SUM_W'(i_head.sum)) * PROD_W'(RECIP)
                      : '0;
        end
        if (a_move) begin
            r_b_data.average_valid <= r_a_done;
            r_b_data.hit           <= b_hit;
            r_b_data.hit_drum      <= r_a_drum;
            r_b_data.average       <= avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            for (int i = 0; i < phq_pkg::PHQ_DRUMS; i++) begin
                r_run[i]  <= '0;
                r_last[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (!i_stall) begin
                r_b_valid <= 1'b0;
            end
            if (a_move) begin
                r_run[r_a_drum] <= n_run;
                if (b_hit) begin
                    r_last[r_a_drum] <= r_a_now;
                end
            end
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    a_hit_needs_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_data.hit |-> r_b_data.average_valid)
        else $error("hit without a completed group");

    a_partial_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !r_b_data.average_valid |-> r_b_data.average == '0)
        else $error("average nonzero on a partial group");

    a_hit_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move && b_hit |=> r_run[r_b_data.hit_drum] == '0)
        else $error("high count not cleared after a hit");

endmodule

[hdl/piezo_hit_qualifier_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piezo_hit_qualifier_unit
// Per-drum piezo hit detector: group averaging, threshold run count and
// wrap-safe cooldown between reported hits.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while o_in_stall is low and returns
// exactly one result beat per sample, in order. A sample is classified in
// the cycle it is accepted and passes through a four-entry queue, a
// multiply stage and the result register; sustained throughput is one
// beat per cycle, limited only by output stalls once the queue fills.
// Configuration writes take effect on the next edge and should be made
// while no sample is in flight.
module piezo_hit_qualifier_unit #(
    parameter int SAMPLES_PER_AVERAGE = phq_pkg::PHQ_SPA_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  phq_pkg::t_in_beat                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output phq_pkg::t_out_beat                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [phq_pkg::PHQ_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [phq_pkg::PHQ_CFG_DATA_W-1:0]   i_cfg_data
);

    phq_pkg::t_cfg  r_cfg;
    phq_pkg::t_work push_work;
    phq_pkg::t_work head_work;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_drum0 <= phq_pkg::PHQ_THR0_RESET;
            r_cfg.threshold_drum1 <= phq_pkg::PHQ_THR1_RESET;
            r_cfg.cooldown_ms     <= phq_pkg::PHQ_COOLDOWN_RESET;
            r_cfg.min_consecutive <= phq_pkg::PHQ_MIN_CONS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                phq_pkg::PHQ_REG_THR0: begin
                    r_cfg.threshold_drum0 <= i_cfg_data[phq_pkg::PHQ_THR_W-1:0];
                end
                phq_pkg::PHQ_REG_THR1: begin
                    r_cfg.threshold_drum1 <= i_cfg_data[phq_pkg::PHQ_THR_W-1:0];
                end
                phq_pkg::PHQ_REG_COOLDOWN: begin
                    r_cfg.cooldown_ms <= i_cfg_data[phq_pkg::PHQ_COOL_W-1:0];
                end
                phq_pkg::PHQ_REG_MIN_CONS: begin
                    r_cfg.min_consecutive <= i_cfg_data[phq_pkg::PHQ_RUN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    phq_front #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_work  (push_work)
    );

    phq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_work)
    );

    phq_back #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_head  (head_work),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
